// File: rtl/wcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types and codes for the weighted cell sampler.
// ----------------------------------------------------------------------------
package wcs_pkg;

    // default table depth
    localparam int WCS_MAX_CELLS = 1024;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] weight;
        logic [31:0] random_fraction;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [9:0] cell_index;
        logic [1:0] status;
    } t_out_item;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_LO,
        S_MUL_HI,
        S_ADD,
        S_PROBE,
        S_CMP,
        S_RESULT
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic mul_lo;
        logic mul_hi;
        logic add;
        logic probe;
        logic compare;
        logic take_index;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       more;
    } t_dp_sts;

endpackage

// File: rtl/weighted_cell_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_cell_sampler
// Weighted cell draw by inverse CDF over a prefix-sum table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one item: clear, append a
//   weight, or draw a sample with a 32-bit uniform fraction. Output channel
//   o_out_valid / i_out_stall returns exactly one result per item, in order.
//   One item is worked on at a time; o_in_stall is low only while idle.
//   Clear, append, error cases and undefined operations go from decode
//   straight to the result state. A sample forms the target with two
//   passes through the shared 32x32 multiplier and an add, then makes
//   at most ceil(log2(cell count)) binary-search probes, each a memory
//   read and a compare.
//   Reset clears the cell count and total; no table sweep is needed.
//   A stalled result is held in the output register; the next item may be
//   accepted and runs until its own result is ready, then waits for the
//   output register to drain.
// ----------------------------------------------------------------------------
module weighted_cell_sampler #(
    parameter int MAX_CELLS = wcs_pkg::WCS_MAX_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  wcs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output wcs_pkg::t_out_item o_out_item
);
    import wcs_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer
    wcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // table and arithmetic
    wcs_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

// File: rtl/wcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_datapath
// Prefix-sum table, running total, shared multiplier and search registers.
// ----------------------------------------------------------------------------
module wcs_datapath #(
    parameter int MAX_CELLS = wcs_pkg::WCS_MAX_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wcs_pkg::t_in_item  i_in_item,
    input  wcs_pkg::t_dp_cmd   i_cmd,
    output wcs_pkg::t_dp_sts   o_sts,
    output wcs_pkg::t_out_item o_out_item
);
    import wcs_pkg::*;

    localparam int IW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int TW = 32 + IW;
    localparam int XW = (CW > 10) ? CW : 10;

    // prefix-sum memory, undefined until written
    logic [TW-1:0] mem [MAX_CELLS];

    t_in_item      r_item;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_total;
    logic [63:0]   r_prod;
    logic [31:0]   r_lo_part;
    logic [TW-1:0] r_target;
    logic [CW-1:0] r_below;
    logic [CW-1:0] r_above;
    logic [CW-1:0] r_mid;
    logic [TW-1:0] r_rd_data;
    logic [9:0]    r_res_index;
    logic [1:0]    r_res_status;
    t_out_item     r_out_item;

    logic [CW-1:0] diff;
    logic [CW-1:0] mid;
    logic          full;
    logic          empty;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [XW-1:0] idx_ext;

    // search midpoint
    assign diff = r_above - r_below;
    assign mid  = r_below + (diff >> 1);

    assign full  = (r_count >= CW'(MAX_CELLS));
    assign empty = (r_count == '0);

    // one shared 32x32 multiplier: low word of the total, then the high part
    assign mul_b = i_cmd.mul_hi ? 32'(r_total[TW-1:32]) : r_total[31:0];
    assign mul_p = 64'(r_item.random_fraction) * 64'(mul_b);

    assign idx_ext = XW'(r_below);

    assign o_sts.op    = r_item.operation;
    assign o_sts.empty = empty;
    assign o_sts.more  = (diff > CW'(1));

    assign o_out_item = r_out_item;

    // table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmd.exec) begin
            if (r_item.operation == OP_CLEAR) begin
                r_count <= '0;
                r_total <= '0;
            end else if (r_item.operation == OP_APPEND && !full) begin
                r_count <= r_count + CW'(1);
                r_total <= r_total + TW'(r_item.weight);
            end
        end
    end

    // memory write on append, registered read on probe
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_item.operation == OP_APPEND && !full) begin
            mem[r_count[IW-1:0]] <= r_total;
        end
        if (i_cmd.probe) begin
            r_rd_data <= mem[mid[IW-1:0]];
        end
    end

    // item capture, target, search and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_res_index <= '0;
            r_below     <= '0;
            r_above     <= r_count;
            if (r_item.operation == OP_APPEND && full) begin
                r_res_status <= ST_FULL;
            end else if (r_item.operation == OP_SAMPLE && empty) begin
                r_res_status <= ST_EMPTY;
            end else begin
                r_res_status <= ST_OK;
            end
        end
        if (i_cmd.mul_lo) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_lo_part <= r_prod[63:32];
            r_prod    <= mul_p;
        end
        if (i_cmd.add) begin
            r_target <= TW'(r_prod) + TW'(r_lo_part);
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.compare) begin
            if (r_rd_data > r_target) begin
                r_above <= r_mid;
            end else begin
                r_below <= r_mid;
            end
        end
        if (i_cmd.take_index) begin
            r_res_index <= idx_ext[9:0];
        end
        if (i_cmd.load_out) begin
            r_out_item.cell_index <= r_res_index;
            r_out_item.status     <= r_res_status;
        end
    end

    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CELLS))
        else $error("cell count beyond table depth");

    // a probe always sits inside a nonempty interval
    a_probe_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.probe |-> (r_below < r_above))
        else $error("probe outside search interval");

    // clear empties the table
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_item.operation == OP_CLEAR) |=>
            (r_count == '0 && r_total == '0))
        else $error("clear left table state");

endmodule

// File: rtl/wcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_ctrl
// Sequencer for decode, target multiply, binary search and result hand-off.
// ----------------------------------------------------------------------------
module wcs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  wcs_pkg::t_dp_sts i_sts,
    output wcs_pkg::t_dp_cmd o_cmd
);
    import wcs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                if (i_sts.op == OP_SAMPLE && !i_sts.empty) begin
                    n_state = S_MUL_LO;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_PROBE;
            end
            S_PROBE: begin
                if (i_sts.more) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_CMP;
                end else begin
                    o_cmd.take_index = 1'b1;
                    n_state          = S_RESULT;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = S_PROBE;
            end
            S_RESULT: begin
                // output register free or draining this cycle
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // an accepted item always goes to decode
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_out && r_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

endmodule

// File: test/wcs_draw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcs_draw_checker
// Watches both channels of the weighted cell sampler, predicts the result of
// every accepted item from its own copy of the prefix-sum table, and compares
// each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module wcs_draw_checker #(
    parameter int MAX_CELLS = wcs_pkg::WCS_MAX_CELLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  wcs_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  wcs_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);
    import wcs_pkg::*;

    // predicted table: prefix sum ahead of each cell, grand total, cells loaded
    logic [41:0] cdf_base [MAX_CELLS];
    logic [41:0] tbl_total = '0;
    int          tbl_count = 0;

    t_out_item   due_results[$];
    int          fails = 0;

    assign o_fail_count = fails;

    // largest cell whose prefix sum does not exceed the target
    function automatic int locate_cell(logic [41:0] goal);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (cdf_base[mid] > goal)
                hi = mid;
            else
                lo = mid;
        end
        return lo;
    endfunction

    // apply one item to the table and return the result it should produce
    function automatic t_out_item predict_result(t_in_item it);
        t_out_item   res;
        logic [73:0] scaled;
        logic [41:0] goal;
        res = '0;
        res.status = ST_OK;
        case (it.operation)
            OP_CLEAR: begin
                tbl_count = 0;
                tbl_total = '0;
            end
            OP_APPEND: begin
                if (tbl_count >= MAX_CELLS) begin
                    res.status = ST_FULL;
                end else begin
                    cdf_base[tbl_count] = tbl_total;
                    tbl_total = tbl_total + 42'(it.weight);
                    tbl_count++;
                end
            end
            OP_SAMPLE: begin
                if (tbl_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // exact floor(fraction * total / 2^32)
                    scaled = 74'(it.random_fraction) * 74'(tbl_total);
                    goal = scaled[73:32];
                    res.cell_index = 10'(locate_cell(goal));
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void note_fail();
        fails++;
    endfunction

    // results are retired before the same edge's input item is predicted
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            tbl_count = 0;
            tbl_total = '0;
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, actual index %0d status %0d",
                             $time, i_out_item.cell_index, i_out_item.status);
                    note_fail();
                end else begin
                    want = due_results.pop_front();
                    if (i_out_item.cell_index !== want.cell_index) begin
                        $display("%0t: cell_index mismatch, expected %0d actual %0d",
                                 $time, want.cell_index, i_out_item.cell_index);
                        note_fail();
                    end
                    if (i_out_item.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, i_out_item.status);
                        note_fail();
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(predict_result(i_in_item));
        end
        o_pending <= due_results.size();
    end

endmodule

// File: test/weighted_cell_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_cell_sampler_tb
// Drives clear, append, draw and undefined items into the sampler: a directed
// sweep of the corner cases, random load-then-draw sequences mixed with noise,
// and a full 1024-cell table with overflow appends. Both channels idle at
// random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module weighted_cell_sampler_tb;

    import wcs_pkg::*;

    localparam int         TABLE_DEPTH = WCS_MAX_CELLS;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 600;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_stall = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    logic      gaps_on = 1'b1;
    int        fail_count;
    int        pending_cnt;
    int        n_clear  = 0;
    int        n_append = 0;
    int        n_draw   = 0;
    int        n_other  = 0;

    weighted_cell_sampler #(
        .MAX_CELLS (TABLE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    wcs_draw_checker #(
        .MAX_CELLS (TABLE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        out_stall <= gaps_on && ($urandom_range(99) < 28);
    end

    // one item: optional idle gap, then hold until accepted
    task automatic put_item(logic [1:0] op, logic [31:0] w, logic [31:0] f);
        @(negedge i_clk);
        if (gaps_on && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item.operation <= op;
        in_item.weight <= w;
        in_item.random_fraction <= f;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        case (op)
            OP_CLEAR:  n_clear++;
            OP_APPEND: n_append++;
            OP_SAMPLE: n_draw++;
            default:   n_other++;
        endcase
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_results_home();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending_cnt == 0);
        repeat (4) @(posedge i_clk);
    endtask

    // weight mix: 0 mixed, 1 all zero, 2 small values
    function automatic logic [31:0] pick_weight(int style);
        if (style == 1)
            return '0;
        if (style == 2)
            return $urandom_range(0, 8);
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom_range(1, 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_fraction();
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_cells(int count, int style);
        repeat (count) put_item(OP_APPEND, pick_weight(style), $urandom);
    endtask

    // stimulus
    initial begin : stim
        int base;
        int done;
        int cells;
        int style;
        bit paused;
        paused = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        put_item(OP_SAMPLE, $urandom, $urandom);           // empty table
        put_item(OP_UNUSED, '1, '1);                       // undefined op
        put_item(OP_APPEND, '0, $urandom);
        put_item(OP_SAMPLE, $urandom, '1);
        put_item(OP_APPEND, '0, $urandom);
        put_item(OP_SAMPLE, $urandom, '0);                 // all weights zero
        put_item(OP_SAMPLE, $urandom, '1);
        put_item(OP_APPEND, '1, $urandom);
        put_item(OP_APPEND, 32'd1, $urandom);
        put_item(OP_APPEND, '0, $urandom);                 // zero-weight cell
        put_item(OP_APPEND, 32'd5, $urandom);
        put_item(OP_SAMPLE, $urandom, '0);
        put_item(OP_SAMPLE, $urandom, '1);
        put_item(OP_SAMPLE, $urandom, 32'h8000_0000);
        put_item(OP_SAMPLE, $urandom, 32'hFFFF_FF00);
        put_item(OP_UNUSED, $urandom, $urandom);
        put_item(OP_SAMPLE, $urandom, 32'h0000_0001);
        put_item(OP_CLEAR, '1, '1);
        put_item(OP_SAMPLE, '0, '0);                       // empty after clear
        put_item(OP_APPEND, '1, '0);
        put_item(OP_APPEND, '1, '0);
        put_item(OP_SAMPLE, $urandom, 32'h7FFF_FFFF);
        put_item(OP_SAMPLE, $urandom, 32'h8000_0000);
        put_item(OP_CLEAR, '0, '0);
        wait_results_home();

        // random load-then-draw sequences, with some noise
        base = n_clear + n_append + n_draw;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            // quiet stretch with no idling on either side
            gaps_on = !(done >= 200 && done < 350);
            if (!paused && done >= 400) begin
                paused = 1'b1;
                wait_results_home();
            end
            if ($urandom_range(99) < 80) begin
                put_item(OP_CLEAR, $urandom, $urandom);
                cells = ($urandom_range(9) == 0) ? $urandom_range(40, 250)
                                                 : $urandom_range(1, 24);
                style = ($urandom_range(9) == 0) ? 1 : ($urandom_range(4) == 0 ? 2 : 0);
                load_cells(cells, style);
                repeat ($urandom_range(2, 12))
                    put_item(OP_SAMPLE, $urandom, pick_fraction());
            end else begin
                repeat ($urandom_range(1, 5))
                    put_item(2'($urandom_range(3)), pick_weight(0), pick_fraction());
            end
            done = n_clear + n_append + n_draw - base;
        end
        gaps_on = 1'b1;
        wait_results_home();

        // full table, overflow appends, then draws across all 1024 cells
        put_item(OP_CLEAR, $urandom, $urandom);
        load_cells(TABLE_DEPTH, 0);
        repeat (3) put_item(OP_APPEND, pick_weight(0), $urandom);
        repeat (30) put_item(OP_SAMPLE, $urandom, pick_fraction());
        put_item(OP_SAMPLE, $urandom, '0);
        put_item(OP_SAMPLE, $urandom, '1);
        put_item(OP_UNUSED, $urandom, $urandom);
        put_item(OP_CLEAR, $urandom, $urandom);
        put_item(OP_SAMPLE, $urandom, $urandom);

        wait_results_home();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d clears, %0d appends, %0d draws, %0d undefined items,",
                 n_clear, n_append, n_draw, n_other);
        $display("with empty-table draws, full-table appends and zero-weight tables.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop
    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending_cnt);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/wcs_pkg.sv
rtl/wcs_datapath.sv
rtl/wcs_ctrl.sv
rtl/weighted_cell_sampler.sv
test/wcs_draw_checker.sv
test/weighted_cell_sampler_tb.sv
